FILE: rtl/core/pfse_pkg.sv
package pfse_pkg;

  // datapath width, fixed by the token and result fields
  localparam int DATA_WIDTH = 32;

  // default operand stack depth
  localparam int STACK_DEPTH_DEF = 64;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // token kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_OPER = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // operator characters
  localparam logic [7:0] CHAR_ADD = 8'h2B;
  localparam logic [7:0] CHAR_SUB = 8'h2D;
  localparam logic [7:0] CHAR_MUL = 8'h2A;
  localparam logic [7:0] CHAR_DIV = 8'h2F;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW  = 3'd1;
  localparam logic [2:0] ST_DIV_ZERO   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN_OP = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  // decoded command classes
  typedef enum logic [2:0] {
    CMD_PUSH,
    CMD_END,
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV,
    CMD_BADOP,
    CMD_BADKIND
  } cmd_op_t;

  // one classified token
  typedef struct packed {
    cmd_op_t               op;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

  // command queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

FILE: rtl/core/pfse_front.sv
module pfse_front (
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic signed [pfse_pkg::DATA_WIDTH-1:0] in_operand_value,
  input  logic [7:0]                      in_operator_char,
  input  logic                            q_full,
  output logic                            q_push,
  output pfse_pkg::cmd_t                  q_cmd
);

  pfse_pkg::cmd_op_t op;

  // classify the token
  always_comb begin
    case (in_kind)
      pfse_pkg::KIND_PUSH: op = pfse_pkg::CMD_PUSH;
      pfse_pkg::KIND_END:  op = pfse_pkg::CMD_END;
      pfse_pkg::KIND_OPER: begin
        case (in_operator_char)
          pfse_pkg::CHAR_ADD: op = pfse_pkg::CMD_ADD;
          pfse_pkg::CHAR_SUB: op = pfse_pkg::CMD_SUB;
          pfse_pkg::CHAR_MUL: op = pfse_pkg::CMD_MUL;
          pfse_pkg::CHAR_DIV: op = pfse_pkg::CMD_DIV;
          default:            op = pfse_pkg::CMD_BADOP;
        endcase
      end
      default: op = pfse_pkg::CMD_BADKIND;
    endcase
  end

  // hand the classified transaction to the queue
  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full;
  assign q_cmd.op     = op;
  assign q_cmd.value  = in_operand_value;

endmodule

FILE: rtl/core/pfse_fifo.sv
module pfse_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pfse_pkg::cmd_t     push_cmd,
  output logic               full,
  input  logic               pop,
  output pfse_pkg::cmd_chan_t head
);

  localparam int PW = (pfse_pkg::QUEUE_DEPTH > 1) ? $clog2(pfse_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(pfse_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(pfse_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULLCNT = CW'(pfse_pkg::QUEUE_DEPTH);

  pfse_pkg::cmd_t entry_r [pfse_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == FULLCNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.cmd   = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: rtl/core/pfse_div.sv
module pfse_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [pfse_pkg::DATA_WIDTH-1:0] dividend,
  input  logic [pfse_pkg::DATA_WIDTH-1:0] divisor,
  output logic                            done,
  output logic [pfse_pkg::DATA_WIDTH-1:0] quotient
);

  localparam int DW = pfse_pkg::DATA_WIDTH;
  localparam int SW = $clog2(DW);
  localparam logic [SW-1:0] LAST_STEP = SW'(DW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          neg_r, neg_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [DW:0]   shifted, diff;

  // one restoring step per cycle on magnitudes
  assign shifted = {rem_r, quo_r[DW-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      neg_nxt  = dividend[DW-1] ^ divisor[DW-1];
      rem_nxt  = '0;
      quo_nxt  = dividend[DW-1] ? -dividend : dividend;
      dvs_nxt  = divisor[DW-1] ? -divisor : divisor;
    end else if (busy_r) begin
      if (!diff[DW]) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      step_nxt = step_r + SW'(1);
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
  end

  // sign fix, truncation toward zero
  assign done     = done_r;
  assign quotient = neg_r ? -quo_r : quo_r;

endmodule

FILE: rtl/core/pfse_back.sv
module pfse_back #(
  parameter int STACK_DEPTH = pfse_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfse_pkg::cmd_chan_t             head,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pfse_pkg::DATA_WIDTH-1:0] out_result_value,
  output logic [2:0]                      out_status,
  output logic                            out_expression_done
);

  localparam int DW = pfse_pkg::DATA_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULLCNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] TWO     = CW'(2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DIV
  } state_t;

  state_t            state_r;
  pfse_pkg::cmd_op_t op_r;
  logic [CW-1:0]     count_r;
  logic [DW-1:0]     tos_r;
  logic [DW-1:0]     res_r;
  logic              out_valid_r;
  logic [DW-1:0]     out_value_r;
  logic [2:0]        out_status_r;
  logic              out_done_r;

  logic [DW-1:0]     stack_mem [STACK_DEPTH];
  logic [DW-1:0]     rd_data_r;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;

  logic              slot_free;
  logic              is_binop;
  logic [DW-1:0]     product;
  logic              div_start, div_done;
  logic [DW-1:0]     div_q;

  assign slot_free = !out_valid_r || !out_stall;
  assign cmd_pop   = (state_r == S_IDLE) && head.valid && slot_free;
  assign is_binop  = (head.cmd.op == pfse_pkg::CMD_ADD) || (head.cmd.op == pfse_pkg::CMD_SUB) ||
                     (head.cmd.op == pfse_pkg::CMD_MUL) || (head.cmd.op == pfse_pkg::CMD_DIV) ||
                     (head.cmd.op == pfse_pkg::CMD_BADOP);

  // top of stack lives in tos_r, lower entries in memory
  assign wr_en   = cmd_pop && (head.cmd.op == pfse_pkg::CMD_PUSH) &&
                   (count_r != '0) && (count_r != FULLCNT);
  assign wr_addr = AW'(count_r - CW'(1));
  assign rd_en   = cmd_pop && is_binop && (count_r >= TWO);
  assign rd_addr = AW'(count_r - TWO);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= tos_r;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  // operand a from memory, b is the top
  assign product   = rd_data_r * tos_r;
  assign div_start = (state_r == S_READ) && (op_r == pfse_pkg::CMD_DIV) && (tos_r != '0);

  pfse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_data_r),
    .divisor  (tos_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer, stack count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            op_r <= head.cmd.op;
            case (head.cmd.op)
              pfse_pkg::CMD_PUSH: begin
                out_valid_r <= 1'b1;
                if (count_r == FULLCNT) begin
                  count_r      <= '0;
                  out_value_r  <= '0;
                  out_status_r <= pfse_pkg::ST_OVERFLOW;
                  out_done_r   <= 1'b1;
                end else begin
                  tos_r        <= head.cmd.value;
                  count_r      <= count_r + CW'(1);
                  out_value_r  <= head.cmd.value;
                  out_status_r <= pfse_pkg::ST_OK;
                  out_done_r   <= 1'b0;
                end
              end
              pfse_pkg::CMD_END: begin
                out_valid_r <= 1'b1;
                out_done_r  <= 1'b1;
                count_r     <= '0;
                if (count_r == '0) begin
                  out_value_r  <= '0;
                  out_status_r <= pfse_pkg::ST_UNDERFLOW;
                end else begin
                  out_value_r  <= tos_r;
                  out_status_r <= pfse_pkg::ST_OK;
                end
              end
              pfse_pkg::CMD_BADKIND: begin
                out_valid_r  <= 1'b1;
                out_done_r   <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= pfse_pkg::ST_UNKNOWN_OP;
                count_r      <= '0;
              end
              default: begin
                // underflow is checked before the operator is decoded
                if (count_r < TWO) begin
                  out_valid_r  <= 1'b1;
                  out_done_r   <= 1'b1;
                  out_value_r  <= '0;
                  out_status_r <= pfse_pkg::ST_UNDERFLOW;
                  count_r      <= '0;
                end else begin
                  state_r <= S_READ;
                end
              end
            endcase
          end
        end
        S_READ: begin
          case (op_r)
            pfse_pkg::CMD_ADD, pfse_pkg::CMD_SUB: begin
              state_r      <= S_IDLE;
              out_valid_r  <= 1'b1;
              out_status_r <= pfse_pkg::ST_OK;
              out_done_r   <= 1'b0;
              count_r      <= count_r - CW'(1);
              if (op_r == pfse_pkg::CMD_ADD) begin
                tos_r       <= rd_data_r + tos_r;
                out_value_r <= rd_data_r + tos_r;
              end else begin
                tos_r       <= rd_data_r - tos_r;
                out_value_r <= rd_data_r - tos_r;
              end
            end
            pfse_pkg::CMD_MUL: begin
              res_r   <= product;
              state_r <= S_MUL;
            end
            pfse_pkg::CMD_DIV: begin
              if (tos_r == '0) begin
                state_r      <= S_IDLE;
                out_valid_r  <= 1'b1;
                out_done_r   <= 1'b1;
                out_value_r  <= '0;
                out_status_r <= pfse_pkg::ST_DIV_ZERO;
                count_r      <= '0;
              end else begin
                state_r <= S_DIV;
              end
            end
            default: begin
              state_r      <= S_IDLE;
              out_valid_r  <= 1'b1;
              out_done_r   <= 1'b1;
              out_value_r  <= '0;
              out_status_r <= pfse_pkg::ST_UNKNOWN_OP;
              count_r      <= '0;
            end
          endcase
        end
        S_MUL: begin
          state_r      <= S_IDLE;
          tos_r        <= res_r;
          count_r      <= count_r - CW'(1);
          out_valid_r  <= 1'b1;
          out_value_r  <= res_r;
          out_status_r <= pfse_pkg::ST_OK;
          out_done_r   <= 1'b0;
        end
        S_DIV: begin
          if (div_done) begin
            state_r      <= S_IDLE;
            tos_r        <= div_q;
            count_r      <= count_r - CW'(1);
            out_valid_r  <= 1'b1;
            out_value_r  <= div_q;
            out_status_r <= pfse_pkg::ST_OK;
            out_done_r   <= 1'b0;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_value    = out_value_r;
  assign out_status          = out_status_r;
  assign out_expression_done = out_done_r;

endmodule

FILE: rtl/core/postfix_stack_evaluator_core.sv
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  in_kind, in_operand_value, in_operator_char
// out_      output     out_valid/out_stall out_result_value, out_status, out_expression_done
//
// push, end, bad kind, underflow: idle state of the back end only; add, subtract, bad op,
// zero divisor: idle, read; multiply: also mul; divide: also div, one quotient bit per cycle
// the command queue holds up to 2 classified tokens while the back end is busy
// synchronous active-low reset empties the stack and the queue; stack memory is not cleared
// a stalled result holds in the output register and the queue keeps taking tokens until full
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = pfse_pkg::STACK_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic signed [pfse_pkg::DATA_WIDTH-1:0] in_operand_value,
  input  logic [7:0]                      in_operator_char,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [pfse_pkg::DATA_WIDTH-1:0] out_result_value,
  output logic [2:0]                      out_status,
  output logic                            out_expression_done
);

  logic                q_full;
  logic                q_push;
  pfse_pkg::cmd_t      q_cmd;
  logic                q_pop;
  pfse_pkg::cmd_chan_t q_head;

  // token classification
  pfse_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_operand_value (in_operand_value),
    .in_operator_char (in_operator_char),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  // command queue
  pfse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  // stack execution
  pfse_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (q_head),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_value    (out_result_value),
    .out_status          (out_status),
    .out_expression_done (out_expression_done)
  );

endmodule

FILE: tb/tb_postfix_stack_evaluator_core.sv
`timescale 1ns / 100ps

module tb_postfix_stack_evaluator_core;

  localparam int DW = pfse_pkg::DATA_WIDTH;
  localparam int TOTAL_TOKENS = 1550;
  localparam int CALM_TAIL = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 60;
  // kind code with no meaning, handled as an unknown operator
  localparam logic [1:0] KIND_BAD = 2'd3;

  // one expected answer from the evaluator
  typedef struct {
    logic [DW-1:0] value;
    logic [2:0]    status;
    logic          done;
  } answer_t;

  // tracks the operand stack and holds the answers still owed by the block
  class rpn_scoreboard;
    logic [DW-1:0] stack_mem [pfse_pkg::STACK_DEPTH_DEF];
    int unsigned   fill;
    answer_t       expected_answers [$];
    int unsigned   errors;

    function new();
      fill = 0;
      errors = 0;
    endfunction

    function void post(logic [DW-1:0] v, logic [2:0] st, logic dn);
      answer_t a;
      a.value = v;
      a.status = st;
      a.done = dn;
      expected_answers.push_back(a);
    endfunction

    // every error empties the stack and closes the expression
    function void abort(logic [2:0] st);
      fill = 0;
      post('0, st, 1'b1);
    endfunction

    // evaluate one accepted token transaction
    function void take_token(logic [1:0] kind, logic [DW-1:0] val, logic [7:0] ch);
      logic [DW-1:0] a, b, r, ma, mb, q;
      bit ok;
      case (kind)
        pfse_pkg::KIND_PUSH: begin
          if (fill >= pfse_pkg::STACK_DEPTH_DEF) abort(pfse_pkg::ST_OVERFLOW);
          else begin
            stack_mem[fill] = val;
            fill++;
            post(val, pfse_pkg::ST_OK, 1'b0);
          end
        end
        pfse_pkg::KIND_END: begin
          if (fill == 0) abort(pfse_pkg::ST_UNDERFLOW);
          else begin
            r = stack_mem[fill-1];
            fill = 0;
            post(r, pfse_pkg::ST_OK, 1'b1);
          end
        end
        pfse_pkg::KIND_OPER: begin
          // underflow wins over operator decode
          if (fill < 2) abort(pfse_pkg::ST_UNDERFLOW);
          else begin
            b = stack_mem[fill-1];
            a = stack_mem[fill-2];
            ok = 1'b1;
            r = '0;
            case (ch)
              pfse_pkg::CHAR_ADD: r = a + b;
              pfse_pkg::CHAR_SUB: r = a - b;
              pfse_pkg::CHAR_MUL: r = a * b;
              pfse_pkg::CHAR_DIV: begin
                if (b == '0) begin
                  ok = 1'b0;
                  abort(pfse_pkg::ST_DIV_ZERO);
                end else begin
                  // truncate toward zero on magnitudes, min / -1 wraps
                  ma = a[DW-1] ? -a : a;
                  mb = b[DW-1] ? -b : b;
                  q = ma / mb;
                  r = (a[DW-1] ^ b[DW-1]) ? -q : q;
                end
              end
              default: begin
                ok = 1'b0;
                abort(pfse_pkg::ST_UNKNOWN_OP);
              end
            endcase
            if (ok) begin
              fill -= 2;
              stack_mem[fill] = r;
              fill++;
              post(r, pfse_pkg::ST_OK, 1'b0);
            end
          end
        end
        default: abort(pfse_pkg::ST_UNKNOWN_OP);
      endcase
    endfunction

    // compare one accepted result transaction with the oldest answer
    function void check_result(logic [DW-1:0] v, logic [2:0] st, logic dn);
      answer_t a;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: result_value %0d status %0d expression_done %0d",
               $signed(v), st, dn);
        errors++;
      end else begin
        a = expected_answers.pop_front();
        if (v !== a.value) begin
          $error("result_value mismatch: expected %0d actual %0d",
                 $signed(a.value), $signed(v));
          errors++;
        end
        if (st !== a.status) begin
          $error("status mismatch: expected %0d actual %0d", a.status, st);
          errors++;
        end
        if (dn !== a.done) begin
          $error("expression_done mismatch: expected %0d actual %0d", a.done, dn);
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_kind = '0;
  logic signed [DW-1:0] in_operand_value = '0;
  logic [7:0]           in_operator_char = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DW-1:0] out_result_value;
  logic [2:0]           out_status;
  logic                 out_expression_done;

  logic                 idle_on = 1'b1;
  int                   stall_left = 0;
  int                   quiet_cycles = 0;
  int                   tokens_sent = 0;
  rpn_scoreboard        rpn_sb;

  postfix_stack_evaluator_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_operand_value    (in_operand_value),
    .in_operator_char    (in_operator_char),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_value    (out_result_value),
    .out_status          (out_status),
    .out_expression_done (out_expression_done)
  );

  always #10 clk = ~clk;

  // result side: check accepted transactions, stall in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall)
        rpn_sb.check_result(out_result_value, out_status, out_expression_done);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 15);
      out_stall <= (stall_left > 0);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("postfix_stack_evaluator_core verification failed");
      $finish;
    end
  end

  // small numbers, the corners of the signed range and, half the time, any 32-bit value
  function automatic logic [DW-1:0] pick_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = '0;
      1:       v = 32'd1;
      2:       v = '1;
      3:       v = 32'h7FFF_FFFF;
      4:       v = 32'h8000_0000;
      5, 6, 7: v = $urandom_range(0, 200) - 100;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_operator();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0:       c = pfse_pkg::CHAR_ADD;
      1:       c = pfse_pkg::CHAR_SUB;
      2:       c = pfse_pkg::CHAR_MUL;
      default: c = pfse_pkg::CHAR_DIV;
    endcase
    return c;
  endfunction

  // drive one token and hold it until the block takes it
  task automatic send_token(input logic [1:0] k, input logic [DW-1:0] v, input logic [7:0] c);
    int gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= k;
    in_operand_value <= v;
    in_operator_char <= c;
    do @(posedge clk); while (in_stall);
    rpn_sb.take_token(k, v, c);
    tokens_sent++;
  endtask

  // hold off the sender until every owed answer is back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (rpn_sb.expected_answers.size() != 0);
  endtask

  // well-formed expression with random operands and operators, its end token sometimes left out
  task automatic run_expression(input int n);
    int pushes_left, ops_left, live;
    bit drop_end;
    pushes_left = n;
    ops_left = n - 1;
    live = 0;
    drop_end = ($urandom_range(0, 9) == 0);
    while (pushes_left > 0 || ops_left > 0) begin
      if (live >= 2 && ops_left > 0 && (pushes_left == 0 || $urandom_range(0, 2) == 0)) begin
        send_token(pfse_pkg::KIND_OPER, $urandom, pick_operator());
        ops_left--;
        live--;
      end else begin
        send_token(pfse_pkg::KIND_PUSH, pick_operand(), 8'($urandom));
        pushes_left--;
        live++;
      end
    end
    if (!drop_end) send_token(pfse_pkg::KIND_END, $urandom, 8'($urandom));
  endtask

  // arbitrary tokens, any kind and any character
  task automatic run_noise(input int n);
    logic [7:0] c;
    repeat (n) begin
      c = ($urandom_range(0, 1) == 0) ? pick_operator() : 8'($urandom);
      send_token(2'($urandom_range(0, 3)), $urandom, c);
    end
  endtask

  // push until the stack overflows
  task automatic run_flood();
    int n;
    n = pfse_pkg::STACK_DEPTH_DEF - rpn_sb.fill + 1;
    repeat (n) send_token(pfse_pkg::KIND_PUSH, $urandom, 8'($urandom));
  endtask

  initial begin
    int pick, n;
    bit paused;
    rpn_sb = new();
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty stack, single entry, wrap, division corners, errors
    send_token(pfse_pkg::KIND_END, 32'h0, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_ADD);
    send_token(pfse_pkg::KIND_PUSH, 32'd7, 8'hFF);
    send_token(pfse_pkg::KIND_OPER, '1, pfse_pkg::CHAR_SUB);
    send_token(pfse_pkg::KIND_PUSH, 32'h7FFF_FFFF, 8'h00);
    send_token(pfse_pkg::KIND_PUSH, 32'd1, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_ADD);
    send_token(pfse_pkg::KIND_PUSH, 32'h8000_0000, 8'h00);
    send_token(pfse_pkg::KIND_PUSH, '1, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_DIV);
    send_token(pfse_pkg::KIND_PUSH, -32'sd7, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_SUB);
    send_token(pfse_pkg::KIND_PUSH, 32'd2, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_DIV);
    send_token(pfse_pkg::KIND_PUSH, 32'h8000_0000, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_MUL);
    send_token(pfse_pkg::KIND_END, '1, 8'hFF);
    send_token(pfse_pkg::KIND_PUSH, 32'd5, 8'h00);
    send_token(pfse_pkg::KIND_PUSH, 32'd0, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, pfse_pkg::CHAR_DIV);
    send_token(pfse_pkg::KIND_PUSH, 32'd1, 8'h00);
    send_token(pfse_pkg::KIND_PUSH, 32'd2, 8'h00);
    send_token(pfse_pkg::KIND_OPER, 32'h0, 8'h25);
    send_token(pfse_pkg::KIND_PUSH, 32'd3, 8'h00);
    send_token(KIND_BAD, '1, pfse_pkg::CHAR_ADD);

    // random phase
    while (tokens_sent < TOTAL_TOKENS) begin
      if (tokens_sent > TOTAL_TOKENS - CALM_TAIL) idle_on <= 1'b0;
      else idle_on <= ($urandom_range(0, 4) != 0);
      if (!paused && tokens_sent > TOTAL_TOKENS / 2) begin
        wait_drain();
        run_flood();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        run_expression(n);
      end else if (pick < 98) begin
        run_noise($urandom_range(1, 6));
      end else begin
        run_flood();
      end
    end

    // let the last answers come back
    in_valid <= 1'b0;
    while (rpn_sb.expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rpn_sb.errors == 0 && rpn_sb.expected_answers.size() == 0)
      $display("postfix_stack_evaluator_core verification clean");
    else
      $display("postfix_stack_evaluator_core verification failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/pfse_pkg.sv
rtl/core/pfse_front.sv
rtl/core/pfse_fifo.sv
rtl/core/pfse_div.sv
rtl/core/pfse_back.sv
rtl/core/postfix_stack_evaluator_core.sv
tb/tb_postfix_stack_evaluator_core.sv
